FILE: src/vertex_pair_dedup_indexer_macros.svh
// ----------------------------------------------------------------------------
// vertex_pair_dedup_indexer_macros
// Assertion macros used by the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef VERTEX_PAIR_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_PAIR_DEDUP_INDEXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPDI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VPDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vpdi_pkg.sv
// ----------------------------------------------------------------------------
// vpdi_pkg
// Types and constants shared by the vertex pair deduplication indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package vpdi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int INDEX_W     = 16;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = SLOT_W + 1;
	localparam int CFG_IDX_W   = 2;

	localparam logic [COUNT_W-1:0] TABLE_FULL_COUNT = COUNT_W'(TABLE_DEPTH);

	// Status codes of a result word.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED     = 2'd1;

	typedef struct packed {
		logic [INDEX_W-1:0] position_index;
		logic [INDEX_W-1:0] texcoord_index;
		logic               first_of_mesh;
		logic               last_of_mesh;
	} item_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  extended_index;
		logic [INDEX_W-1:0] original_index;
		logic               is_new;
		logic [COUNT_W-1:0] unique_count;
		logic [1:0]         status;
	} result_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic issue_rd;
		logic capture;
		logic load_out;
	} vpdi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic ptr_at_end;
		logic rd_pending;
		logic out_free;
	} vpdi_stat_t;

endpackage

`default_nettype wire

FILE: src/vpdi_ctrl.sv
// ----------------------------------------------------------------------------
// vpdi_ctrl
// Sequencer for one corner: accept, scan the pair table, then emit a result.
// ----------------------------------------------------------------------------
`default_nettype none

module vpdi_ctrl import vpdi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire vpdi_stat_t stat,
	output vpdi_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		item_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit) begin
					cmd.capture = 1'b1;
					state_d     = ST_RESULT;
				end else if (stat.ptr_at_end && !stat.rd_pending) begin
					// Every stored pair has been compared without a match.
					cmd.capture = 1'b1;
					state_d     = ST_RESULT;
				end else if (!stat.ptr_at_end) begin
					cmd.issue_rd = 1'b1;
				end
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/vpdi_datapath.sv
// ----------------------------------------------------------------------------
// vpdi_datapath
// Pair table memory, scan pointer, entry count, config and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_pair_dedup_indexer_macros.svh"

module vpdi_datapath import vpdi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire item_word_t           item,
	input  wire vpdi_cmd_t            cmd,
	output vpdi_stat_t                stat,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_word_t              result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_data
);

	logic [2*INDEX_W-1:0] pair_mem [TABLE_DEPTH];

	logic [INDEX_W-1:0]   pos_q;
	logic [INDEX_W-1:0]   tex_q;
	logic                 last_q;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   ptr_q;
	logic [2*INDEX_W-1:0] rdata_s1;
	logic [SLOT_W-1:0]    addr_s1;
	logic                 rd_valid_s1;
	logic                 found_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 check_en_q;
	logic [COUNT_W-1:0]   expected_q;
	logic                 out_valid_q;
	result_word_t         out_q;

	logic                 hit;
	logic                 insert;
	logic                 full;
	logic [COUNT_W-1:0]   new_count;
	result_word_t         out_d;

	assign hit    = rd_valid_s1 && (rdata_s1 == {pos_q, tex_q});
	assign full   = (count_q == TABLE_FULL_COUNT);
	assign insert = cmd.load_out && !found_q && !full;

	assign stat.hit        = hit;
	assign stat.ptr_at_end = (ptr_q == count_q);
	assign stat.rd_pending = rd_valid_s1;
	assign stat.out_free   = !out_valid_q || !result_stall;

	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		new_count           = count_q;
		out_d.original_index = pos_q;
		out_d.is_new        = 1'b0;
		out_d.extended_index = slot_q;
		out_d.status        = STATUS_OK;
		if (!found_q) begin
			if (full) begin
				out_d.extended_index = '0;
				out_d.status         = STATUS_FULL;
			end else begin
				out_d.extended_index = count_q[SLOT_W-1:0];
				out_d.is_new         = 1'b1;
				new_count            = count_q + COUNT_W'(1);
			end
		end
		// A full table outranks a count mismatch.
		if (last_q && check_en_q && (out_d.status == STATUS_OK) &&
		    (new_count != expected_q)) begin
			out_d.status = STATUS_MISMATCH;
		end
		out_d.unique_count = new_count;
	end

	// Simple dual-port style table: one write at the append slot, one registered read.
	always_ff @(posedge clk) begin
		if (insert) begin
			pair_mem[count_q[SLOT_W-1:0]] <= {pos_q, tex_q};
		end
		rdata_s1 <= pair_mem[ptr_q[SLOT_W-1:0]];
		addr_s1  <= ptr_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			pos_q  <= item.position_index;
			tex_q  <= item.texcoord_index;
			last_q <= item.last_of_mesh;
		end
		if (cmd.capture) begin
			found_q <= hit;
			slot_q  <= addr_s1;
		end
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			check_en_q  <= 1'b0;
			expected_q  <= '0;
		end else begin
			rd_valid_s1 <= cmd.issue_rd;
			if (cmd.load_item) begin
				ptr_q <= '0;
				if (item.first_of_mesh) begin
					count_q <= '0;
				end
			end else if (cmd.issue_rd) begin
				ptr_q <= ptr_q + COUNT_W'(1);
			end
			if (insert) begin
				count_q <= new_count;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHECK_ENABLE: check_en_q <= cfg_data[0];
					CFG_EXPECTED:     expected_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	`VPDI_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= TABLE_FULL_COUNT, "entry count beyond table depth")
	`VPDI_ASSERT_SAME(a_insert_room, clk, arst_n, insert, count_q < TABLE_FULL_COUNT, "append into a full table")
	`VPDI_ASSERT_SAME(a_read_in_range, clk, arst_n, cmd.issue_rd, ptr_q < count_q, "scan read beyond stored pairs")
	`VPDI_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.load_out, !(out_valid_q && result_stall), "result overwritten while stalled")
	`VPDI_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, out_valid_q, "loaded result not shown as valid")

endmodule

`default_nettype wire

FILE: src/vertex_pair_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_pair_dedup_indexer
// Deduplicates (position, texture) index pairs into extended vertex indexes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Word
//  item     | item_valid/item_stall  | item_word_t: position, texcoord, first, last
//  result   | result_valid/result_stall | result_word_t: slot, echo, new, count, status
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data (11 bits)
//
// A scan ends on the first hit, or on a miss once every stored pair has been
// compared, also on a full table; an empty table needs no comparison.
// The pair memory is read through its single read port, one stored pair per cycle.
// Reset clears the entry count and config; the table needs no clearing pass.
// A stalled result is held in the output register while the next corner is
// accepted and scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_pair_dedup_indexer import vpdi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_word_t           item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_word_t              result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_data
);

	vpdi_cmd_t  cmd;
	vpdi_stat_t stat;

	vpdi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	vpdi_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

`default_nettype wire
